// ===== src/csp_pkg.sv =====
// Package for the credit share thread picker: transaction structs, command
// codes, cell control struct, controller states and default parameters.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

  localparam int NUM_THREADS_DEF = 8;
  localparam int CREDIT_BITS_DEF = 8;

  localparam logic SLOT_ON = 1'b1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_PICK  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [2:0] slot_index;
    logic       slot_active;
    logic [7:0] slot_priority;
    logic [7:0] slot_credits;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [2:0] chosen_slot;
    logic       refilled;
    logic       task_active;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic refill;
    logic dec;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } ctl_state_t;

endpackage

`default_nettype wire

// ===== src/csp_cell.sv =====
// One thread slot of the picker chain: holds active flag, priority and
// credits, and passes the running best-slot token to the next cell.
// Depends on csp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csp_cell #(
  parameter int IDX_W       = 3,
  parameter int CREDIT_BITS = csp_pkg::CREDIT_BITS_DEF,
  parameter int CELL_INDEX  = 0
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire csp_pkg::cell_ctl_t    ctl,
  input  wire                        wr_active,
  input  wire  [CREDIT_BITS-1:0]     wr_priority,
  input  wire  [CREDIT_BITS-1:0]     wr_credits,
  input  wire                        tok_in_any,
  input  wire  [IDX_W-1:0]           tok_in_idx,
  input  wire  [CREDIT_BITS-1:0]     tok_in_cred,
  output logic                       tok_out_any,
  output logic [IDX_W-1:0]           tok_out_idx,
  output logic [CREDIT_BITS-1:0]     tok_out_cred
);

  logic                   active;
  logic [CREDIT_BITS-1:0] prio;
  logic [CREDIT_BITS-1:0] cred;
  logic [CREDIT_BITS-1:0] cred_base;
  logic [CREDIT_BITS-1:0] cred_next;
  logic                   take;

  always_comb begin
    cred_base = (ctl.refill && active == csp_pkg::SLOT_ON) ? prio : cred;
    cred_next = (ctl.dec && cred_base != '0) ? cred_base - 1'b1 : cred_base;
    take      = (active == csp_pkg::SLOT_ON) && (!tok_in_any || cred > tok_in_cred);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      prio   <= '0;
      cred   <= '0;
    end else if (ctl.load) begin
      active <= wr_active;
      prio   <= wr_priority;
      cred   <= wr_credits;
    end else begin
      cred   <= cred_next;
    end
  end

  // token stage: keep the incoming best or replace it with this slot
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_any  <= 1'b0;
      tok_out_idx  <= '0;
      tok_out_cred <= '0;
    end else if (take) begin
      tok_out_any  <= 1'b1;
      tok_out_idx  <= IDX_W'(CELL_INDEX);
      tok_out_cred <= cred;
    end else begin
      tok_out_any  <= tok_in_any;
      tok_out_idx  <= tok_in_idx;
      tok_out_cred <= tok_in_cred;
    end
  end

endmodule

`default_nettype wire

// ===== src/credit_share_thread_picker.sv =====
// Top level of the credit share thread picker: controller, result register
// and the chain of slot cells. Depends on csp_pkg and csp_cell.
//
//   channel  | direction | payload        | handshake
//   req      | in        | csp_pkg::req_t | req_valid / req_stall
//   rsp      | out       | csp_pkg::rsp_t | rsp_valid / rsp_stall
//
// A write lands in its slot at the accept edge; its transaction shows on rsp
// in the following cycle. A pick scans in ST_SCAN while the best-slot token
// ripples one cell per cycle down the chain, then updates credits in ST_APPLY
// and registers its result there once rsp is free.
// rst is synchronous and clears all slots. A stalled rsp blocks new requests
// and holds a finished pick in its update cycle.
`timescale 1ns / 1ps
`default_nettype none

module credit_share_thread_picker #(
  parameter int NUM_THREADS = csp_pkg::NUM_THREADS_DEF,
  parameter int CREDIT_BITS = csp_pkg::CREDIT_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  wire csp_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output csp_pkg::rsp_t       rsp
);

  localparam int IDX_W = $clog2(NUM_THREADS);

  csp_pkg::ctl_state_t state;
  csp_pkg::ctl_state_t state_next;
  logic [IDX_W-1:0]    cnt;
  logic [IDX_W-1:0]    cnt_next;
  csp_pkg::rsp_t       result;
  csp_pkg::rsp_t       result_next;
  logic                result_valid;
  logic                result_load;
  logic                out_free;
  logic                wr_go;
  logic                apply_go;

  logic                   tok_any  [NUM_THREADS+1];
  logic [IDX_W-1:0]       tok_idx  [NUM_THREADS+1];
  logic [CREDIT_BITS-1:0] tok_cred [NUM_THREADS+1];
  csp_pkg::cell_ctl_t     cell_ctl [NUM_THREADS];

  logic                   best_any;
  logic [IDX_W-1:0]       best_idx;
  logic [CREDIT_BITS-1:0] best_cred;
  logic                   do_refill;

  assign tok_any[0]  = 1'b0;
  assign tok_idx[0]  = '0;
  assign tok_cred[0] = '0;

  assign best_any  = tok_any[NUM_THREADS];
  assign best_idx  = tok_idx[NUM_THREADS];
  assign best_cred = tok_cred[NUM_THREADS];

  assign out_free  = !result_valid || !rsp_stall;
  assign req_stall = !(state == csp_pkg::ST_IDLE && out_free);
  assign rsp_valid = result_valid;
  assign rsp       = result;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    result_next = result;
    result_load = 1'b0;
    wr_go       = 1'b0;
    apply_go    = 1'b0;
    unique case (state)
      csp_pkg::ST_IDLE: begin
        if (req_valid && !req_stall) begin
          if (req.command == csp_pkg::CMD_WRITE) begin
            wr_go       = 1'b1;
            result_load = 1'b1;
            result_next = '{found: 1'b0, chosen_slot: 3'd0, refilled: 1'b0,
                            task_active: 1'b1};
          end else begin
            cnt_next   = '0;
            state_next = csp_pkg::ST_SCAN;
          end
        end
      end
      csp_pkg::ST_SCAN: begin
        cnt_next = cnt + 1'b1;
        if (cnt == IDX_W'(NUM_THREADS - 1)) begin
          state_next = csp_pkg::ST_APPLY;
        end
      end
      csp_pkg::ST_APPLY: begin
        if (out_free) begin
          apply_go    = best_any;
          result_load = 1'b1;
          result_next = '{found: best_any,
                          chosen_slot: best_any ? 3'(best_idx) : 3'd0,
                          refilled: best_any && best_cred == '0,
                          task_active: best_any};
          state_next  = csp_pkg::ST_IDLE;
        end
      end
      default: state_next = csp_pkg::ST_IDLE;
    endcase
  end

  assign do_refill = apply_go && best_cred == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= csp_pkg::ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!rsp_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result <= result_next;
    end
  end

  for (genvar i = 0; i < NUM_THREADS; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].load   = wr_go && int'(req.slot_index) == i;
      cell_ctl[i].refill = do_refill;
      cell_ctl[i].dec    = apply_go && int'(best_idx) == i;
    end

    csp_cell #(
      .IDX_W       (IDX_W),
      .CREDIT_BITS (CREDIT_BITS),
      .CELL_INDEX  (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (cell_ctl[i]),
      .wr_active    (req.slot_active),
      .wr_priority  (CREDIT_BITS'(req.slot_priority)),
      .wr_credits   (CREDIT_BITS'(req.slot_credits)),
      .tok_in_any   (tok_any[i]),
      .tok_in_idx   (tok_idx[i]),
      .tok_in_cred  (tok_cred[i]),
      .tok_out_any  (tok_any[i+1]),
      .tok_out_idx  (tok_idx[i+1]),
      .tok_out_cred (tok_cred[i+1])
    );
  end

endmodule

`default_nettype wire

// ===== src/csp_checker.sv =====
// Port-level checks for the credit share thread picker, bound to the top.
// Depends on csp_pkg and credit_share_thread_picker.
`timescale 1ns / 1ps
`default_nettype none

module csp_checker (
  input wire                clk,
  input wire                rst,
  input wire                req_valid,
  input wire                req_stall,
  input wire csp_pkg::req_t req,
  input wire                rsp_valid,
  input wire                rsp_stall,
  input wire csp_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled rsp transaction changed");

  a_write_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.command == csp_pkg::CMD_WRITE
    |=> rsp_valid && !rsp.found && !rsp.refilled && rsp.task_active
        && rsp.chosen_slot == 3'd0)
    else $error("write transaction without its result");

  a_pick_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.command == csp_pkg::CMD_PICK |=> req_stall)
    else $error("request taken while a pick is in flight");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> !rsp.refilled && rsp.chosen_slot == 3'd0)
    else $error("empty pick reports a slot or a refill");

  a_found_active: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.task_active)
    else $error("found pick without task_active");

endmodule

bind credit_share_thread_picker csp_checker u_csp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

// ===== verif/csp_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for credit_share_thread_picker: mirrors the slot table, predicts
// every response from accepted requests and compares it field by field.
// Depends on csp_pkg.
module csp_scoreboard #(
  parameter int NUM_THREADS = csp_pkg::NUM_THREADS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  csp_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  csp_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);

  logic          slot_on   [NUM_THREADS];
  logic [7:0]    slot_prio [NUM_THREADS];
  logic [7:0]    slot_cred [NUM_THREADS];
  csp_pkg::rsp_t sched_due [$];
  int            mismatches = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Applies one command to the mirrored table and returns the decision.
  function automatic csp_pkg::rsp_t schedule_step(input csp_pkg::req_t r);
    csp_pkg::rsp_t res;
    int            best;
    bit            seen;
    logic [7:0]    most;
    res = '0;
    best = 0;
    seen = 1'b0;
    most = '0;
    if (r.command == csp_pkg::CMD_WRITE) begin
      if (r.slot_index < NUM_THREADS) begin
        slot_on[r.slot_index]   = r.slot_active;
        slot_prio[r.slot_index] = r.slot_priority;
        slot_cred[r.slot_index] = r.slot_credits;
      end
      res.task_active = 1'b1;
      return res;
    end
    for (int i = 0; i < NUM_THREADS; i++) begin
      if (slot_on[i] == csp_pkg::SLOT_ON && (!seen || slot_cred[i] > most)) begin
        seen = 1'b1;
        best = i;
        most = slot_cred[i];
      end
    end
    if (!seen) return res;
    if (most == 0) begin
      res.refilled = 1'b1;
      for (int i = 0; i < NUM_THREADS; i++)
        if (slot_on[i] == csp_pkg::SLOT_ON) slot_cred[i] = slot_prio[i];
    end
    // a zero-priority winner stays at zero after the refill
    if (slot_cred[best] != 0) slot_cred[best] = slot_cred[best] - 8'd1;
    res.found = 1'b1;
    res.chosen_slot = best[2:0];
    res.task_active = 1'b1;
    return res;
  endfunction

  task automatic flag_error(input string what, input csp_pkg::rsp_t want,
                            input csp_pkg::rsp_t got);
    if (mismatches < 10)
      $display({"%0t rsp %s: exp found=%0b slot=%0d refill=%0b active=%0b,",
                " got found=%0b slot=%0d refill=%0b active=%0b"},
               $time, what, want.found, want.chosen_slot, want.refilled,
               want.task_active, got.found, got.chosen_slot, got.refilled,
               got.task_active);
    mismatches++;
  endtask

  always @(posedge clk) begin
    csp_pkg::rsp_t want;
    if (rst) begin
      for (int i = 0; i < NUM_THREADS; i++) begin
        slot_on[i] = 1'b0;
        slot_prio[i] = '0;
        slot_cred[i] = '0;
      end
      sched_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (sched_due.size() == 0) begin
          flag_error("unexpected transaction", '0, rsp);
        end else begin
          want = sched_due.pop_front();
          if (rsp.found !== want.found || rsp.chosen_slot !== want.chosen_slot ||
              rsp.refilled !== want.refilled || rsp.task_active !== want.task_active)
            flag_error("mismatch", want, rsp);
        end
      end
      if (req_valid && !req_stall) sched_due.push_back(schedule_step(req));
    end
    pending <= sched_due.size();
    fail_count <= mismatches;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for credit_share_thread_picker: clock, reset, directed and
// random request stimulus, random response stalls and the verdict.
// Depends on csp_pkg, credit_share_thread_picker and csp_scoreboard.
module tb;

  localparam int ITEMS      = 1500;
  localparam int QUIET_TAIL = 150;
  localparam int IDLE_LIMIT = 2000;
  localparam int REQ_W      = $bits(csp_pkg::req_t);

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  csp_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  csp_pkg::rsp_t rsp;
  int            fail_count;
  int            pending;
  bit            idle_off = 1'b0;
  int            stall_left = 0;
  int            quiet_cycles = 0;

  always #10 clk = ~clk;

  credit_share_thread_picker dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  csp_scoreboard chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // response-side stall bursts
  always @(posedge clk) begin
    if (idle_off)
      stall_left = 0;
    else if (stall_left > 0)
      stall_left = stall_left - 1;
    else if (!rst && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 19);
    rsp_stall <= (stall_left > 0);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input csp_pkg::req_t item);
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic write_slot(input int idx, input bit act, input int prio, input int cred);
    csp_pkg::req_t item;
    item.command = csp_pkg::CMD_WRITE;
    item.slot_index = idx[2:0];
    item.slot_active = act;
    item.slot_priority = prio[7:0];
    item.slot_credits = cred[7:0];
    send_item(item);
  endtask

  // unused fields of a pick carry random bits
  task automatic pick_next();
    csp_pkg::req_t item;
    item = csp_pkg::req_t'(REQ_W'($urandom));
    item.command = csp_pkg::CMD_PICK;
    send_item(item);
  endtask

  function automatic logic [7:0] rand_amount();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'hff;
      2:       return 8'($urandom_range(1, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    csp_pkg::req_t item;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed
    pick_next();                      // empty table
    write_slot(7, 1, 255, 255);
    write_slot(0, 1, 0, 0);
    pick_next();                      // slot 7 wins
    write_slot(3, 1, 1, 254);
    pick_next();                      // tie at 254, lowest index wins
    write_slot(5, 0, 8'haa, 8'h55);   // inactive slot ignored
    pick_next();
    write_slot(7, 1, 255, 0);
    write_slot(3, 1, 1, 0);
    write_slot(0, 1, 0, 0);
    pick_next();                      // all zero: refill, zero-priority winner stays at zero
    pick_next();
    write_slot(0, 0, 0, 0);
    write_slot(3, 0, 0, 0);
    write_slot(7, 0, 0, 0);
    pick_next();                      // nothing active again

    // random
    for (int n = 0; n < ITEMS; n++) begin
      if (n % 100 == 0 && n < ITEMS - QUIET_TAIL)
        idle_off <= ($urandom_range(0, 3) == 0);
      if (n == ITEMS - QUIET_TAIL) idle_off <= 1'b1;
      if (!idle_off && n < ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      if ($urandom_range(0, 9) < 6) begin
        pick_next();
      end else begin
        item.command = csp_pkg::CMD_WRITE;
        item.slot_index = 3'($urandom_range(0, 7));
        item.slot_active = ($urandom_range(0, 3) != 0);
        item.slot_priority = rand_amount();
        item.slot_credits = rand_amount();
        send_item(item);
      end
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (csp_pkg::NUM_THREADS_DEF + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
